FILE: sv/amrp_pkg.sv
package amrp_pkg;

    // Fixed widths of the stored state.
    localparam int FRAMES_W = 4;
    localparam int BYTES_W  = 10;

    // Configuration register indexes.
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_WIDEBAND    = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TOC   = 2'd1;
    localparam logic [1:0] KIND_REF   = 2'd2;

    localparam logic [7:0]  CMR_BYTE    = 8'hF0;
    localparam logic [7:0]  TOC_FT_MASK = 8'h78;
    localparam logic [7:0]  TOC_Q_BIT   = 8'h04;
    localparam logic [7:0]  TOC_F_BIT   = 8'h80;
    localparam logic [12:0] TICKS_NB    = 13'd160;
    localparam logic [12:0] TICKS_WB    = 13'd320;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;

    // One held frame as it sits in the frame memory.
    typedef struct packed {
        logic [7:0]  toc;
        logic [31:0] sample;
        logic [15:0] offset;
        logic [5:0]  length;
    } frame_entry_t;

    // Single-port access to the frame memory.
    typedef struct packed {
        logic                we;
        logic                re;
        logic [FRAMES_W-1:0] addr;
        frame_entry_t        wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] ref_sample;
        logic [15:0] data_offset;
        logic [5:0]  data_length;
        logic [11:0] duration;
        logic        marker;
        logic        last;
    } result_t;

    // Speech byte count for a frame type; types with no size give 0.
    function automatic logic [5:0] speech_len(input logic [3:0] ft, input logic wb);
        logic [5:0] len;
        len = 6'd0;
        if (wb)
        begin
            case (ft)
                4'd0:    len = 6'd17;
                4'd1:    len = 6'd23;
                4'd2:    len = 6'd32;
                4'd3:    len = 6'd36;
                4'd4:    len = 6'd40;
                4'd5:    len = 6'd46;
                4'd6:    len = 6'd50;
                4'd7:    len = 6'd58;
                4'd8:    len = 6'd60;
                4'd9:    len = 6'd5;
                4'd10:   len = 6'd5;
                default: len = 6'd0;
            endcase
        end
        else
        begin
            case (ft)
                4'd0:    len = 6'd12;
                4'd1:    len = 6'd13;
                4'd2:    len = 6'd15;
                4'd3:    len = 6'd17;
                4'd4:    len = 6'd19;
                4'd5:    len = 6'd20;
                4'd6:    len = 6'd26;
                4'd7:    len = 6'd31;
                4'd8:    len = 6'd5;
                default: len = 6'd0;
            endcase
        end
        return len;
    endfunction

endpackage

FILE: sv/amr_rtp_packetizer_top.sv
// AMR / AMR-WB octet-aligned RTP payload packetizer. Each request on the input
// channel is one speech frame (header byte, sample id, header offset, end-of-track
// flag). Frames are packed greedily: a frame is held if its speech bytes plus the
// held speech and table-of-contents bytes stay within max_payload and at most
// MAX_FRAMES frames are held; else a nonempty held packet is flushed first, and an
// end-of-track frame is added and then flushed with the RTP marker set. A flush emits
// a packet-start result, the CMR byte, one table-of-contents byte per frame and one
// speech data reference per frame, and the last result caused by a request carries
// last. The held frames live in a single-port frame memory with a registered read. A
// frame that causes no flush is accepted and then written into it; a flush gives the
// start and CMR results, then for each table-of-contents byte and data reference a
// memory read and a step that loads the output register. No request is taken until
// the previous one is done. A result sits in an output register, so a stall on the
// output never blocks the internal read of the next entry already requested.
// Configuration may be written only while no request is in flight.
module amr_rtp_packetizer_top
    import amrp_pkg::*;
#(
    parameter int MAX_FRAMES = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_header,
    input  logic [31:0] sample_id,
    input  logic [15:0] header_offset,
    input  logic        end_of_track,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [31:0] ref_sample,
    output logic [15:0] data_offset,
    output logic [5:0]  data_length,
    output logic [11:0] duration,
    output logic        marker,
    output logic        last
);

    logic [15:0]  max_payload_reg;
    logic         wideband_reg;
    mem_req_t     mem_req;
    frame_entry_t mem_rd_data;
    result_t      result;

    // Configuration registers; the index selects which one a write lands in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            wideband_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_WIDEBAND:    wideband_reg    <= cfg_data[0];
                default:         max_payload_reg <= max_payload_reg;
            endcase
        end
    end

    // Sequencer: packing decision, frame writes and flush bursts.
    amrp_ctrl #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_payload   (max_payload_reg),
        .wideband      (wideband_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_header  (frame_header),
        .sample_id     (sample_id),
        .header_offset (header_offset),
        .end_of_track  (end_of_track),
        .mem_req       (mem_req),
        .mem_rd_data   (mem_rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_result    (result)
    );

    // Held frames: table-of-contents byte and data reference per slot.
    amrp_frame_mem #(
        .DEPTH (MAX_FRAMES)
    ) u_frame_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign kind        = result.kind;
    assign byte_value  = result.byte_value;
    assign ref_sample  = result.ref_sample;
    assign data_offset = result.data_offset;
    assign data_length = result.data_length;
    assign duration    = result.duration;
    assign marker      = result.marker;
    assign last        = result.last;

endmodule

FILE: sv/amrp_frame_mem.sv
module amrp_frame_mem
    import amrp_pkg::*;
#(
    parameter int DEPTH = 12
)
(
    input  logic         clk,
    input  mem_req_t     req,
    output frame_entry_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    frame_entry_t mem [DEPTH];
    frame_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/amrp_ctrl.sv
module amrp_ctrl
    import amrp_pkg::*;
#(
    parameter int MAX_FRAMES = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [15:0]  max_payload,
    input  logic         wideband,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   frame_header,
    input  logic [31:0]  sample_id,
    input  logic [15:0]  header_offset,
    input  logic         end_of_track,
    output mem_req_t     mem_req,
    input  frame_entry_t mem_rd_data,
    output logic         out_valid,
    input  logic         out_stall,
    output result_t      out_result
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_START   = 4'd1;
    localparam logic [3:0] ST_CMR     = 4'd2;
    localparam logic [3:0] ST_TOC_RD  = 4'd3;
    localparam logic [3:0] ST_TOC_OUT = 4'd4;
    localparam logic [3:0] ST_REF_RD  = 4'd5;
    localparam logic [3:0] ST_REF_OUT = 4'd6;
    localparam logic [3:0] ST_WRITE   = 4'd7;

    localparam logic [FRAMES_W-1:0] MAX_N = FRAMES_W'(MAX_FRAMES);

    logic [3:0]          state_reg, state_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [FRAMES_W-1:0] idx_reg, idx_next;
    logic                final_reg, final_next;
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg, result_next;

    logic [7:0]          hdr_reg;
    logic [31:0]         sample_reg;
    logic [15:0]         offset_reg;
    logic                eot_reg;
    logic [5:0]          len_reg;

    logic                accept;
    logic                out_free;
    logic [5:0]          in_len;
    logic [10:0]         fill_sum;
    logic                pre_flush;
    logic                idx_is_last;
    logic [11:0]         dur_full;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_len    = speech_len(frame_header[6:3], wideband);
    assign fill_sum  = {1'b0, bytes_reg} + {5'd0, in_len};
    assign pre_flush = (({5'd0, fill_sum} > max_payload) || (frames_reg >= MAX_N))
                       && (frames_reg != '0);

    assign idx_is_last = ((idx_reg + 1'b1) == frames_reg);
    assign dur_full    = 12'(13'(frames_reg) * (wideband ? TICKS_WB : TICKS_NB));

    always_comb
    begin
        state_next     = state_reg;
        frames_next    = frames_reg;
        bytes_next     = bytes_reg;
        idx_next       = idx_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        mem_req        = '0;
        mem_req.addr   = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    final_next = 1'b0;
                    state_next = pre_flush ? ST_START : ST_WRITE;
                end
            end
            ST_START:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    result_next          = '0;
                    result_next.kind     = KIND_START;
                    result_next.duration = dur_full;
                    result_next.marker   = final_reg;
                    state_next           = ST_CMR;
                end
            end
            ST_CMR:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    result_next            = '0;
                    result_next.kind       = KIND_TOC;
                    result_next.byte_value = CMR_BYTE;
                    idx_next               = '0;
                    state_next             = ST_TOC_RD;
                end
            end
            ST_TOC_RD:
            begin
                mem_req.re = 1'b1;
                state_next = ST_TOC_OUT;
            end
            ST_TOC_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    result_next            = '0;
                    result_next.kind       = KIND_TOC;
                    result_next.byte_value = mem_rd_data.toc
                                             | (idx_is_last ? 8'h00 : TOC_F_BIT);
                    if (idx_is_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_REF_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TOC_RD;
                    end
                end
            end
            ST_REF_RD:
            begin
                mem_req.re = 1'b1;
                state_next = ST_REF_OUT;
            end
            ST_REF_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    result_next             = '0;
                    result_next.kind        = KIND_REF;
                    result_next.ref_sample  = mem_rd_data.sample;
                    result_next.data_offset = mem_rd_data.offset;
                    result_next.data_length = mem_rd_data.length;
                    // The very last result of the request closes it, unless the new
                    // frame still has to be flushed on its own at end of track.
                    result_next.last        = idx_is_last && (final_reg || !eot_reg);
                    if (idx_is_last)
                    begin
                        frames_next = '0;
                        bytes_next  = '0;
                        state_next  = final_reg ? ST_IDLE : ST_WRITE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_REF_RD;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_req.we            = 1'b1;
                mem_req.addr          = frames_reg;
                mem_req.wdata.toc     = (hdr_reg & TOC_FT_MASK) | TOC_Q_BIT;
                mem_req.wdata.sample  = sample_reg;
                mem_req.wdata.offset  = offset_reg + 16'd1;
                mem_req.wdata.length  = len_reg;
                frames_next           = frames_reg + 1'b1;
                bytes_next            = BYTES_W'({1'b0, bytes_reg} + {5'd0, len_reg} + 11'd1);
                if (eot_reg)
                begin
                    final_next = 1'b1;
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frames_reg    <= '0;
            bytes_reg     <= '0;
            idx_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            bytes_reg     <= bytes_next;
            idx_reg       <= idx_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            hdr_reg    <= frame_header;
            sample_reg <= sample_id;
            offset_reg <= header_offset;
            eot_reg    <= end_of_track;
            len_reg    <= in_len;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

FILE: sv/amrp_checker.sv
module amrp_checker
    import amrp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  byte_value,
    input logic [31:0] ref_sample,
    input logic [15:0] data_offset,
    input logic [5:0]  data_length,
    input logic [11:0] duration,
    input logic        marker,
    input logic        last
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_value)
            && $stable(ref_sample) && $stable(data_offset) && $stable(data_length)
            && $stable(duration) && $stable(marker) && $stable(last))
        else $error("stalled result changed");

    // An empty packet is never started.
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_START |-> duration != 12'd0 && last == 1'b0)
        else $error("packet start with zero duration or last");

    // Only a data reference can close a request.
    a_last_ref: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_REF)
        else $error("last on a result that is not a data reference");

    // Marker and duration appear only on a packet start.
    a_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_START |-> duration == 12'd0 && marker == 1'b0)
        else $error("duration or marker outside a packet start");

    // A request is never taken while the previous one is still being worked on.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted in back-to-back cycles");

endmodule

bind amr_rtp_packetizer_top amrp_checker u_checker (.*);

FILE: test/tb.sv
// Testbench for the AMR / AMR-WB RTP packetizer.
//
// Frame requests go in on the input channel. At each accepted request a
// behavioral packer works out the results that the request should cause. It
// holds its own frame store, byte count and register copies. Those results
// wait in a queue, and every accepted result is compared with the oldest one,
// field by field.
//
// A short directed table comes first. It covers the field extremes, an invalid
// frame type, an oversized frame, no flush with nothing held, a full packet of
// twelve frames and the offset wrap. Random phases follow, each under its own
// register setting. Both sides idle at random, in stretches.
module tb;
    import amrp_pkg::*;

    localparam int FRAMES_MAX = 12;
    localparam int DRAIN_CYCLES = 64;

    // Speech byte counts per frame type, narrowband and wideband.
    localparam logic [5:0] NB_SPEECH_BYTES [16] =
        '{12, 13, 15, 17, 19, 20, 26, 31, 5, 0, 0, 0, 0, 0, 0, 0};
    localparam logic [5:0] WB_SPEECH_BYTES [16] =
        '{17, 23, 32, 36, 40, 46, 50, 58, 60, 5, 5, 0, 0, 0, 0, 0};

    // One row of stimulus. It is either a register setting or a frame request.
    // A frame row may carry up to four results that are typed in by hand.
    typedef struct packed {
        logic          is_cfg;
        logic [15:0]   cap;
        logic          wb;
        logic [7:0]    hdr;
        logic [31:0]   sid;
        logic [15:0]   hoff;
        logic          eot;
        logic          typed;
        logic [2:0]    want_n;
        result_t [3:0] want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  frame_header;
    logic [31:0] sample_id;
    logic [15:0] header_offset;
    logic        end_of_track;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] ref_sample;
    logic [15:0] data_offset;
    logic [5:0]  data_length;
    logic [11:0] duration;
    logic        marker;
    logic        last;

    // Packer state and register copies.
    logic [7:0]  toc_mem [FRAMES_MAX];
    logic [31:0] sid_mem [FRAMES_MAX];
    logic [15:0] off_mem [FRAMES_MAX];
    logic [5:0]  len_mem [FRAMES_MAX];
    int          held_frames = 0;
    logic [9:0]  held_bytes = '0;
    logic [15:0] payload_cap = MAX_PAYLOAD_RESET;
    logic        wb_mode = 1'b0;

    result_t     owed_results [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          in_left = 0;
    logic        in_gaps_on = 1'b0;

    amr_rtp_packetizer_top #(.MAX_FRAMES(FRAMES_MAX)) u_top (.*);

    always #5 clk = ~clk;

    function automatic result_t mk_res(logic [1:0] k, logic [7:0] b, logic [31:0] s,
                                       logic [15:0] o, logic [5:0] l, logic [11:0] d,
                                       logic m, logic lst);
        result_t r;
        r.kind        = k;
        r.byte_value  = b;
        r.ref_sample  = s;
        r.data_offset = o;
        r.data_length = l;
        r.duration    = d;
        r.marker      = m;
        r.last        = lst;
        return r;
    endfunction

    function automatic stim_row_t frame_row(logic [7:0] hdr, logic [31:0] sid,
                                            logic [15:0] hoff, logic eot);
        stim_row_t r;
        r      = '0;
        r.hdr  = hdr;
        r.sid  = sid;
        r.hoff = hoff;
        r.eot  = eot;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [15:0] cap, logic wb);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.cap    = cap;
        r.wb     = wb;
        return r;
    endfunction

    // Emits the held packet: start, CMR byte, TOC entries, then data references.
    function automatic void emit_packet(logic mark);
        int n;
        n = held_frames;
        if (n == 0)
            return;
        owed_results.push_back(mk_res(KIND_START, '0, '0, '0, '0,
            12'(n * int'(wb_mode ? TICKS_WB : TICKS_NB)), mark, 1'b0));
        owed_results.push_back(mk_res(KIND_TOC, CMR_BYTE, '0, '0, '0, '0, 1'b0, 1'b0));
        for (int i = 0; i < n; i++)
            owed_results.push_back(mk_res(KIND_TOC,
                toc_mem[i] | ((i + 1 < n) ? TOC_F_BIT : 8'h00),
                '0, '0, '0, '0, 1'b0, 1'b0));
        for (int i = 0; i < n; i++)
            owed_results.push_back(mk_res(KIND_REF, '0, sid_mem[i], off_mem[i], len_mem[i],
                '0, 1'b0, 1'b0));
        held_frames = 0;
        held_bytes  = '0;
    endfunction

    // Packs one frame, flushing ahead of it when it does not fit.
    function automatic void pack_frame(logic [7:0] hdr, logic [31:0] sid,
                                       logic [15:0] hoff, logic eot);
        int         n0;
        int         slot;
        logic [5:0] len;
        n0  = owed_results.size();
        len = wb_mode ? WB_SPEECH_BYTES[hdr[6:3]] : NB_SPEECH_BYTES[hdr[6:3]];
        if (int'(held_bytes) + int'(len) > int'(payload_cap) || held_frames >= FRAMES_MAX)
            emit_packet(1'b0);
        slot = (held_frames >= FRAMES_MAX) ? FRAMES_MAX - 1 : held_frames;
        toc_mem[slot] = (hdr & TOC_FT_MASK) | TOC_Q_BIT;
        sid_mem[slot] = sid;
        off_mem[slot] = hoff + 16'd1;
        len_mem[slot] = len;
        held_frames   = slot + 1;
        held_bytes    = held_bytes + 10'(len) + 10'd1;
        if (eot)
            emit_packet(1'b1);
        if (owed_results.size() > n0)
            owed_results[owed_results.size() - 1].last = 1'b1;
    endfunction

    // Drives one frame request and waits for it to be taken. The valid line stays
    // high into the next request when no gap is drawn.
    task automatic send_frame(input stim_row_t r);
        int gap;
        int n0;
        if (in_left == 0)
        begin
            in_gaps_on = ($urandom_range(0, 2) != 0);
            in_left    = $urandom_range(8, 24);
        end
        in_left--;
        gap = in_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        frame_header  <= r.hdr;
        sample_id     <= r.sid;
        header_offset <= r.hoff;
        end_of_track  <= r.eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // The request was taken at this edge.
        n0 = owed_results.size();
        pack_frame(r.hdr, r.sid, r.hoff, r.eot);
        if (r.typed)
        begin
            while (owed_results.size() > n0)
                void'(owed_results.pop_back());
            for (int k = 0; k < int'(r.want_n); k++)
                owed_results.push_back(r.want[k]);
        end
    endtask

    // Lets every owed result arrive and the last request settle before a
    // register write.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] cap, input logic wb);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_index <= REG_WIDEBAND;
        cfg_data  <= {15'($urandom), wb};
        @(posedge clk);
        cfg_we      <= 1'b0;
        payload_cap = cap;
        wb_mode     = wb;
    endtask

    // Result side: stalls a random number of cycles before each result, in
    // stretches, and checks every accepted result against the oldest one owed.
    initial
    begin
        int      gap;
        int      out_left;
        logic    out_gaps_on;
        result_t due;
        out_left    = 0;
        out_gaps_on = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (out_left == 0)
            begin
                out_gaps_on = ($urandom_range(0, 2) != 0);
                out_left    = $urandom_range(8, 24);
            end
            out_left--;
            gap = out_gaps_on ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: kind %0d", kind);
                mismatches++;
            end
            else
            begin
                due = owed_results.pop_front();
                if (kind !== due.kind)
                begin
                    $error("kind: expected %0d, got %0d", due.kind, kind);
                    mismatches++;
                end
                if (byte_value !== due.byte_value)
                begin
                    $error("byte_value: expected %0h, got %0h", due.byte_value, byte_value);
                    mismatches++;
                end
                if (ref_sample !== due.ref_sample)
                begin
                    $error("ref_sample: expected %0h, got %0h", due.ref_sample, ref_sample);
                    mismatches++;
                end
                if (data_offset !== due.data_offset)
                begin
                    $error("data_offset: expected %0d, got %0d", due.data_offset, data_offset);
                    mismatches++;
                end
                if (data_length !== due.data_length)
                begin
                    $error("data_length: expected %0d, got %0d", due.data_length, data_length);
                    mismatches++;
                end
                if (duration !== due.duration)
                begin
                    $error("duration: expected %0d, got %0d", due.duration, duration);
                    mismatches++;
                end
                if (marker !== due.marker)
                begin
                    $error("marker: expected %0d, got %0d", due.marker, marker);
                    mismatches++;
                end
                if (last !== due.last)
                begin
                    $error("last: expected %0d, got %0d", due.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t  r;
        logic [15:0] cap;
        logic        wb;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_MAX_PAYLOAD;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        frame_header  <= '0;
        sample_id     <= '0;
        header_offset <= '0;
        end_of_track  <= 1'b0;

        // Directed table. Rows with results typed in start from an empty packet.
        // Top offset and all-ones sample, alone in a packet with the marker.
        r = frame_row(8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        r.typed = 1'b1;
        r.want_n = 3'd4;
        r.want[0] = mk_res(KIND_START, '0, '0, '0, '0, 12'd160, 1'b1, 1'b0);
        r.want[1] = mk_res(KIND_TOC, CMR_BYTE, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[2] = mk_res(KIND_TOC, 8'h04, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[3] = mk_res(KIND_REF, '0, 32'hFFFF_FFFF, 16'h0000, 6'd12, '0, 1'b0, 1'b1);
        directed_rows.push_back(r);
        // Invalid narrowband type with every header bit set: no speech bytes.
        r = frame_row(8'hFF, 32'h0, 16'h0, 1'b1);
        r.typed = 1'b1;
        r.want_n = 3'd4;
        r.want[0] = mk_res(KIND_START, '0, '0, '0, '0, 12'd160, 1'b1, 1'b0);
        r.want[1] = mk_res(KIND_TOC, CMR_BYTE, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[2] = mk_res(KIND_TOC, 8'h7C, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[3] = mk_res(KIND_REF, '0, 32'h0, 16'h0001, 6'd0, '0, 1'b0, 1'b1);
        directed_rows.push_back(r);
        // Twelve frames of types 0 to 11 fill a packet. The thirteenth frame
        // flushes them and then goes out alone at end of track.
        for (int i = 0; i < 12; i++)
            directed_rows.push_back(frame_row(8'(i << 3) | ((i % 2 == 1) ? 8'h87 : 8'h00),
                32'hA5A5_0000 + 32'(i), 16'(i * 3), 1'b0));
        directed_rows.push_back(frame_row(8'h38, 32'h5A5A_5A5A, 16'h8000, 1'b1));
        // A zero payload limit on wideband. The first frame, with nothing held, flushes
        // nothing, and the next two frames each push out the oversized one before it.
        directed_rows.push_back(cfg_row(16'h0000, 1'b1));
        r = frame_row(8'h40, 32'h1234_5678, 16'd100, 1'b0);
        r.typed = 1'b1;
        r.want_n = 3'd0;
        directed_rows.push_back(r);
        directed_rows.push_back(frame_row(8'h48, 32'h0F0F_0F0F, 16'd200, 1'b0));
        directed_rows.push_back(frame_row(8'h58, 32'hF0F0_F0F0, 16'd300, 1'b1));
        r = frame_row(8'h50, 32'hDEAD_BEEF, 16'h7FFF, 1'b1);
        r.typed = 1'b1;
        r.want_n = 3'd4;
        r.want[0] = mk_res(KIND_START, '0, '0, '0, '0, 12'd320, 1'b1, 1'b0);
        r.want[1] = mk_res(KIND_TOC, CMR_BYTE, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[2] = mk_res(KIND_TOC, 8'h54, '0, '0, '0, '0, 1'b0, 1'b0);
        r.want[3] = mk_res(KIND_REF, '0, 32'hDEAD_BEEF, 16'h8000, 6'd5, '0, 1'b0, 1'b1);
        directed_rows.push_back(r);
        // The largest limit on wideband: the longest frame, an invalid type and the
        // smallest type share one packet.
        directed_rows.push_back(cfg_row(16'hFFFF, 1'b1));
        directed_rows.push_back(frame_row(8'h40, 32'h0000_0001, 16'd1, 1'b0));
        directed_rows.push_back(frame_row(8'h78, 32'h8000_0000, 16'd2, 1'b0));
        directed_rows.push_back(frame_row(8'h00, 32'h7FFF_FFFF, 16'hFFFE, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle();
                set_config(directed_rows[i].cap, directed_rows[i].wb);
            end
            else
                send_frame(directed_rows[i]);
        end

        // Random phases. Most frames carry a type with a size in the current table.
        // The rest carry any header. The final frame closes the track.
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            wb = 1'($urandom);
            case ($urandom_range(0, 5))
                0:       cap = 16'h0000;
                1:       cap = 16'hFFFF;
                2:       cap = MAX_PAYLOAD_RESET;
                3:       cap = 16'($urandom_range(1, 80));
                4:       cap = 16'($urandom_range(60, 400));
                default: cap = 16'($urandom);
            endcase
            if (p == 0)
            begin
                cap = 16'hFFFF;
                wb  = 1'b0;
            end
            else if (p == 1)
            begin
                cap = 16'h0000;
                wb  = 1'b0;
            end
            set_config(cap, wb);
            for (int j = 0; j < 48; j++)
            begin
                r = frame_row(8'($urandom), $urandom, 16'($urandom),
                              ($urandom_range(0, 11) == 0) || (p == 7 && j == 47));
                if ($urandom_range(0, 99) < 85)
                    r.hdr[6:3] = wb_mode ? 4'($urandom_range(0, 10)) : 4'($urandom_range(0, 8));
                send_frame(r);
            end
        end

        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: amr_rtp_packetizer_top.f
sv/amrp_pkg.sv
sv/amrp_frame_mem.sv
sv/amrp_ctrl.sv
sv/amr_rtp_packetizer_top.sv
sv/amrp_checker.sv
test/tb.sv
